[src/gregorian_date_normalizer_unit_macros.svh]
// Assertion macros used by the checker file of the date normaliser.
// No dependencies; take in with `include before the checker module.
`ifndef GREGORIAN_DATE_NORMALIZER_UNIT_MACROS_SVH
`define GREGORIAN_DATE_NORMALIZER_UNIT_MACROS_SVH

// Same-cycle implication.
`define GDN_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication.
`define GDN_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

[src/gdn_pkg.sv]
// Shared types, constants and the month-length function for the date normaliser.
// No dependencies.
package gdn_pkg;

   localparam int DAY_WIDTH_DEFAULT  = 16;
   localparam int YEAR_WIDTH_DEFAULT = 16;

   // working month holds up to 255 plus one carry
   localparam int MONTH_W = 9;
   // remainder of the year modulo the leap cycle
   localparam int REM_W   = 9;

   localparam int LEAP_CYCLE = 400;
   localparam int CENTURY    = 100;

   // cycles spent on the year-modulo-400 unit: quotient, then remainder
   localparam int MOD_CYCLES = 2;

   localparam logic [MONTH_W-1:0] MONTHS_PER_YEAR = MONTH_W'(12);
   localparam logic [MONTH_W-1:0] MONTH_FEB       = MONTH_W'(2);
   localparam logic [MONTH_W-1:0] MONTH_APR       = MONTH_W'(4);
   localparam logic [MONTH_W-1:0] MONTH_JUN       = MONTH_W'(6);
   localparam logic [MONTH_W-1:0] MONTH_SEP       = MONTH_W'(9);
   localparam logic [MONTH_W-1:0] MONTH_NOV       = MONTH_W'(11);

   localparam logic [4:0] DAYS_LONG     = 5'd31;
   localparam logic [4:0] DAYS_SHORT    = 5'd30;
   localparam logic [4:0] DAYS_FEB_LEAP = 5'd29;
   localparam logic [4:0] DAYS_FEB      = 5'd28;

   typedef struct packed {
      logic [15:0] in_day;
      logic [7:0]  in_month;
      logic [15:0] in_year;
   } req_data_type;

   typedef struct packed {
      logic [4:0]  out_day;
      logic [3:0]  out_month;
      logic [15:0] out_year;
      logic        year_overflow;
   } rsp_data_type;

   typedef struct packed {
      logic load;
      logic mod_step;
      logic pass_step;
      logic out_load;
   } cmd_type;

   typedef struct packed {
      logic pass_more;
   } status_type;

   // Months outside one to twelve count as long months.
   function automatic logic [4:0] month_len(input logic [MONTH_W-1:0] month,
                                            input logic leap);
      logic [4:0] len;
      unique case (month) inside
         MONTH_APR, MONTH_JUN, MONTH_SEP, MONTH_NOV: len = DAYS_SHORT;
         MONTH_FEB: len = leap ? DAYS_FEB_LEAP : DAYS_FEB;
         default: len = DAYS_LONG;
      endcase
      return len;
   endfunction

endpackage

[src/gdn_datapath.sv]
// Datapath of the date normaliser: working day/month/year registers, the
// year-modulo-400 unit and the result register. Uses gdn_pkg.
module gdn_datapath #(
   parameter int DAY_WIDTH  = gdn_pkg::DAY_WIDTH_DEFAULT,
   parameter int YEAR_WIDTH = gdn_pkg::YEAR_WIDTH_DEFAULT
) (
   input  logic                  clock,
   input  gdn_pkg::req_data_type req_data,
   input  gdn_pkg::cmd_type      cmd,
   output gdn_pkg::status_type   status,
   output gdn_pkg::rsp_data_type rsp_data
);

   localparam int MW = gdn_pkg::MONTH_W;
   localparam int RW = gdn_pkg::REM_W;

   // year / 400 fits in YEAR_WIDTH-8 bits; reciprocal with YEAR_WIDTH+9 fraction bits
   localparam int QW    = YEAR_WIDTH - 8;
   localparam int MUL_K = YEAR_WIDTH + 9;
   localparam int PW    = 2 * YEAR_WIDTH + 1;
   localparam logic [YEAR_WIDTH:0] RECIP =
      (YEAR_WIDTH+1)'(((64'd1 << MUL_K) + 64'(gdn_pkg::LEAP_CYCLE - 1)) /
                      64'(gdn_pkg::LEAP_CYCLE));

   logic [DAY_WIDTH-1:0]  day_ff, day_in;
   logic [MW-1:0]         month_ff, month_in;
   logic [YEAR_WIDTH-1:0] year_ff, year_in;
   logic [QW-1:0]         quot_ff, quot_in;
   logic [RW-1:0]         rem_ff, rem_in;
   logic                  ovf_ff, ovf_in;
   gdn_pkg::rsp_data_type rsp_data_ff, rsp_data_in;

   logic [31:0]           day_wide, year_wide, year_cur_wide;
   logic                  leap;
   logic [4:0]            len;
   logic [DAY_WIDTH-1:0]  len_ext;
   logic                  day_over, month_over;
   logic [MW-1:0]         month_step;
   logic [PW-1:0]         prod;
   logic [YEAR_WIDTH-1:0] quot_scaled, rem_full;

   assign day_wide      = 32'(req_data.in_day);
   assign year_wide     = 32'(req_data.in_year);
   assign year_cur_wide = 32'(year_ff);

   // Leap test on the remainder: 4 divides 400, so the low bits decide.
   assign leap = (rem_ff == '0) ||
                 ((rem_ff[1:0] == 2'b00) &&
                  (rem_ff != RW'(gdn_pkg::CENTURY)) &&
                  (rem_ff != RW'(2 * gdn_pkg::CENTURY)) &&
                  (rem_ff != RW'(3 * gdn_pkg::CENTURY)));

   assign len        = gdn_pkg::month_len(month_ff, leap);
   assign len_ext    = DAY_WIDTH'(len);
   assign day_over   = day_ff > len_ext;
   assign month_over = month_ff > gdn_pkg::MONTHS_PER_YEAR;
   assign month_step = day_over ? month_ff + MW'(1) : month_ff;

   assign prod        = PW'(year_ff) * PW'(RECIP);
   assign quot_scaled = YEAR_WIDTH'(quot_ff) * YEAR_WIDTH'(gdn_pkg::LEAP_CYCLE);
   assign rem_full    = year_ff - quot_scaled;

   assign status.pass_more = day_over || month_over;

   always_comb begin
      day_in      = day_ff;
      month_in    = month_ff;
      year_in     = year_ff;
      quot_in     = quot_ff;
      rem_in      = rem_ff;
      ovf_in      = ovf_ff;
      rsp_data_in = rsp_data_ff;
      if (cmd.load) begin
         day_in   = day_wide[DAY_WIDTH-1:0];
         month_in = MW'(req_data.in_month);
         year_in  = year_wide[YEAR_WIDTH-1:0];
         rem_in   = '0;
         ovf_in   = 1'b0;
      end else if (cmd.mod_step) begin
         // quotient by reciprocal multiplication; the remainder is valid after the second step
         quot_in = prod[MUL_K+QW-1:MUL_K];
         rem_in  = rem_full[RW-1:0];
      end else if (cmd.pass_step) begin
         day_in   = day_over ? day_ff - len_ext : day_ff;
         month_in = month_step;
         if (month_step > gdn_pkg::MONTHS_PER_YEAR) begin
            month_in = month_step - gdn_pkg::MONTHS_PER_YEAR;
            if (year_ff == '1) begin
               // saturate: year and remainder hold
               ovf_in = 1'b1;
            end else begin
               year_in = year_ff + YEAR_WIDTH'(1);
               rem_in  = (rem_ff == RW'(gdn_pkg::LEAP_CYCLE - 1)) ? '0 : rem_ff + RW'(1);
            end
         end
      end
      if (cmd.out_load) begin
         rsp_data_in.out_day       = day_ff[4:0];
         rsp_data_in.out_month     = month_ff[3:0];
         rsp_data_in.out_year      = year_cur_wide[15:0];
         rsp_data_in.year_overflow = ovf_ff;
      end
   end

   always_ff @(posedge clock) begin
      day_ff      <= day_in;
      month_ff    <= month_in;
      year_ff     <= year_in;
      quot_ff     <= quot_in;
      rem_ff      <= rem_in;
      ovf_ff      <= ovf_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_data = rsp_data_ff;

endmodule

[src/gdn_controller.sv]
// Controller of the date normaliser: sequences load, modulo steps, carry
// passes and the result transfer. Uses gdn_pkg command and status types.
module gdn_controller (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   input  gdn_pkg::status_type status,
   output gdn_pkg::cmd_type    cmd
);

   localparam int CNT_W = 1;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_MOD,
      ST_PASS
   } state_type;

   state_type        state_ff, state_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic             slot_free;

   assign slot_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               cnt_in   = CNT_W'(gdn_pkg::MOD_CYCLES - 1);
               state_in = ST_MOD;
            end
         end
         ST_MOD: begin
            cmd.mod_step = 1'b1;
            if (cnt_ff == '0) begin
               state_in = ST_PASS;
            end else begin
               cnt_in = cnt_ff - CNT_W'(1);
            end
         end
         ST_PASS: begin
            if (status.pass_more) begin
               cmd.pass_step = 1'b1;
            end else if (slot_free) begin
               cmd.out_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      if (cmd.out_load) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

endmodule

[src/gregorian_date_normalizer_unit.sv]
// Top level of the Gregorian date normaliser: controller plus datapath.
// Depends on gdn_pkg, gdn_controller and gdn_datapath.
//
//   channel   direction  handshake             payload
//   req       in         req_valid/req_stall   gdn_pkg::req_data_type
//   rsp       out        rsp_valid/rsp_stall   gdn_pkg::rsp_data_type
//
// An item goes through the load, the year-modulo-400 unit, the carry passes
// (one month subtracted per pass, up to about 2200 for a 16-bit day) and
// the result transfer; the modulo unit gives quotient, then remainder.
// Reset is synchronous and clears the controller; the result register is
// free and the input channel is ready on the cycle after reset.
// A stalled result holds in its register while the next item is taken in;
// the next result waits in the working registers until the register is free.
module gregorian_date_normalizer_unit #(
   parameter int DAY_WIDTH  = gdn_pkg::DAY_WIDTH_DEFAULT,
   parameter int YEAR_WIDTH = gdn_pkg::YEAR_WIDTH_DEFAULT
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  gdn_pkg::req_data_type req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output gdn_pkg::rsp_data_type rsp_data
);

   gdn_pkg::cmd_type    cmd;
   gdn_pkg::status_type status;

   gdn_controller u_controller (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .status    (status),
      .cmd       (cmd)
   );

   gdn_datapath #(
      .DAY_WIDTH (DAY_WIDTH),
      .YEAR_WIDTH(YEAR_WIDTH)
   ) u_datapath (
      .clock    (clock),
      .req_data (req_data),
      .cmd      (cmd),
      .status   (status),
      .rsp_data (rsp_data)
   );

endmodule

[src/gdn_checker.sv]
// Port-level assertions for the date normaliser, bound to its top level.
// Depends on gdn_pkg and gregorian_date_normalizer_unit_macros.svh.
`include "gregorian_date_normalizer_unit_macros.svh"

module gdn_checker (
   input logic                  clock,
   input logic                  reset,
   input logic                  req_valid,
   input logic                  req_stall,
   input gdn_pkg::req_data_type req_data,
   input logic                  rsp_valid,
   input logic                  rsp_stall,
   input gdn_pkg::rsp_data_type rsp_data
);

   logic req_xfer;
   logic month_ok;

   assign req_xfer = req_valid && !req_stall && (req_data == req_data);
   assign month_ok = rsp_data.out_month <= 4'(gdn_pkg::MONTHS_PER_YEAR);

   // one item at a time: a transfer in makes the block busy
   `GDN_ASSERT_NEXT(a_busy_after_req, clock, reset, req_xfer, req_stall, "not busy after transfer")
   `GDN_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_data), "stalled result changed")
   `GDN_ASSERT_NOW(a_month_range, clock, reset, rsp_valid, month_ok, "result month above twelve")
   `GDN_ASSERT_NEXT(a_reset_clear, clock, 1'b0, reset, !rsp_valid && !req_stall, "reset left block busy")

endmodule

bind gregorian_date_normalizer_unit gdn_checker u_gdn_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_stall (req_stall),
   .req_data  (req_data),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);
